// File: rtl/fcsm_pkg.sv
// Package for the flash command state machine: sizes, codes and types.
package fcsm_pkg;

    // Array geometry
    localparam int ARRAY_BYTES = 131072;
    localparam int BLOCK_BYTES = 65536;

    localparam int ADDR_W     = 17;
    localparam int DATA_W     = 16;
    localparam int CMD_W      = 8;
    localparam int WORD_COUNT = ARRAY_BYTES / 2;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int BYTE_AW    = WORD_AW + 1;
    localparam int OFF_W      = (BYTE_AW > ADDR_W) ? BYTE_AW : ADDR_W;

    // Erase range in words, clipped to the array
    localparam int ERASE_WORDS =
        ((BLOCK_BYTES < ARRAY_BYTES) ? BLOCK_BYTES : ARRAY_BYTES) / 2;
    localparam logic [WORD_AW-1:0] ERASE_MASK = WORD_AW'(ERASE_WORDS - 1);
    localparam logic [WORD_AW-1:0] FULL_MASK  = '1;

    localparam logic [DATA_W-1:0] ERASED_WORD    = '1;
    localparam logic [DATA_W-1:0] STATUS_DONE    = 16'h0080;
    localparam logic [DATA_W-1:0] STATUS_PGM_ERR = 16'h0010;

    localparam logic [DATA_W-1:0] MANUF_ID_RESET  = 16'h0089;
    localparam logic [DATA_W-1:0] DEVICE_ID_RESET = 16'h0000;

    // Command codes (low byte of a write)
    localparam logic [CMD_W-1:0] CMD_PROGRAM      = 8'h40;
    localparam logic [CMD_W-1:0] CMD_PROGRAM_ALT  = 8'h10;
    localparam logic [CMD_W-1:0] CMD_ERASE_SETUP  = 8'h20;
    localparam logic [CMD_W-1:0] CMD_LOCK_SETUP   = 8'h60;
    localparam logic [CMD_W-1:0] CMD_CONFIRM      = 8'hd0;
    localparam logic [CMD_W-1:0] CMD_LOCK_ALT     = 8'h01;
    localparam logic [CMD_W-1:0] CMD_READ_ARRAY   = 8'hff;
    localparam logic [CMD_W-1:0] CMD_READ_ID      = 8'h90;
    localparam logic [CMD_W-1:0] CMD_READ_STATUS  = 8'h70;
    localparam logic [CMD_W-1:0] CMD_CLEAR_STATUS = 8'h50;
    localparam logic [CMD_W-1:0] CMD_SUSPEND      = 8'hb0;

    // Configuration register indexes
    localparam logic CFG_MANUF_ID  = 1'b0;
    localparam logic CFG_DEVICE_ID = 1'b1;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_RESET = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_ARRAY  = 2'd0,
        MODE_ID     = 2'd1,
        MODE_STATUS = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        PEND_NONE    = 2'd0,
        PEND_PROGRAM = 2'd1,
        PEND_ERASE   = 2'd2,
        PEND_LOCK    = 2'd3
    } t_pend;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROG,
        S_ERASE
    } t_state;

endpackage

// File: rtl/fcsm_ram.sv
// Generic single-port RAM with registered read (read-first).
module fcsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: rtl/flash_command_state_machine.sv
// Top level: command user interface of a 16-bit NOR flash with its word array.
//
// One transaction is one bus access (read, write or device reset), taken when
// start is high and busy is low. Every transaction returns exactly one
// o_read_data word, strobed by o_strobe in the cycle after it is taken; the
// receiver cannot stall it. Reads, plain commands and device resets leave busy
// low, so they can be issued back to back. A program confirm reads the word
// from the array RAM, ANDs it with the data and writes it back through the
// single RAM port, holding busy in S_PROG for the write-back. A block erase
// confirm holds busy while the erase sweep writes the block, one word per cycle.
// After reset, busy stays high while all WORD_COUNT words (65536 at the default
// size) are swept to all ones; configuration writes are accepted during that
// time.
module flash_command_state_machine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_action,
    input  logic [fcsm_pkg::ADDR_W-1:0] i_address,
    input  logic [fcsm_pkg::DATA_W-1:0] i_write_data,
    output logic                        o_strobe,
    output logic [fcsm_pkg::DATA_W-1:0] o_read_data,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [fcsm_pkg::DATA_W-1:0] i_cfg_wdata
);

    localparam int WORD_AW = fcsm_pkg::WORD_AW;
    localparam int DATA_W  = fcsm_pkg::DATA_W;
    localparam int OFF_W   = fcsm_pkg::OFF_W;

    // Control state
    fcsm_pkg::t_state r_state, n_state;
    fcsm_pkg::t_mode  r_mode,  n_mode;
    fcsm_pkg::t_pend  r_pend,  n_pend;
    logic             r_err,   n_err;
    logic             r_strobe, n_strobe;
    logic             r_use_ram, n_use_ram;
    logic [WORD_AW-1:0] r_sweep_addr, n_sweep_addr;
    logic [WORD_AW-1:0] r_sweep_mask, n_sweep_mask;

    // Payload
    logic [DATA_W-1:0]  r_result, n_result;
    logic [WORD_AW-1:0] r_prog_idx, n_prog_idx;
    logic [DATA_W-1:0]  r_prog_data, n_prog_data;

    // Config registers
    logic [DATA_W-1:0] r_manuf_id;
    logic [DATA_W-1:0] r_device_id;

    // RAM port
    logic               ram_we;
    logic [WORD_AW-1:0] ram_addr;
    logic [DATA_W-1:0]  ram_wdata;
    logic [DATA_W-1:0]  ram_rdata;

    // Decode
    logic                        accept;
    logic [OFF_W-1:0]            off;
    logic [WORD_AW-1:0]          word_idx;
    logic [fcsm_pkg::CMD_W-1:0]  cmd;
    fcsm_pkg::t_action           action;
    logic [DATA_W-1:0]           prog_word;
    logic                        sweep_done;

    assign busy   = (r_state != fcsm_pkg::S_IDLE);
    assign accept = start && !busy;
    assign action = fcsm_pkg::t_action'(i_action);
    assign cmd    = i_write_data[fcsm_pkg::CMD_W-1:0];

    // Byte offset masked to the array and forced even
    assign off = OFF_W'(i_address) & OFF_W'(fcsm_pkg::ARRAY_BYTES - 1) & ~OFF_W'(1);
    assign word_idx = off[fcsm_pkg::BYTE_AW-1:1];

    assign prog_word  = ram_rdata & r_prog_data;
    assign sweep_done = ((r_sweep_addr & r_sweep_mask) == r_sweep_mask);

    // Single RAM port: sweep, program write-back, or lookup for the incoming access
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = word_idx;
        ram_wdata = fcsm_pkg::ERASED_WORD;
        case (r_state)
            fcsm_pkg::S_CLEAR, fcsm_pkg::S_ERASE: begin
                ram_we   = 1'b1;
                ram_addr = r_sweep_addr;
            end
            fcsm_pkg::S_PROG: begin
                ram_we    = 1'b1;
                ram_addr  = r_prog_idx;
                ram_wdata = prog_word;
            end
            default: begin
                ram_we   = 1'b0;
                ram_addr = word_idx;
            end
        endcase
    end

    fcsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (fcsm_pkg::WORD_COUNT)
    ) u_array (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Next state and command decode
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_pend       = r_pend;
        n_err        = r_err;
        n_strobe     = 1'b0;
        n_use_ram    = 1'b0;
        n_result     = '0;
        n_sweep_addr = r_sweep_addr;
        n_sweep_mask = r_sweep_mask;
        n_prog_idx   = r_prog_idx;
        n_prog_data  = r_prog_data;

        case (r_state)
            fcsm_pkg::S_CLEAR, fcsm_pkg::S_ERASE: begin
                if (sweep_done) begin
                    n_state = fcsm_pkg::S_IDLE;
                end else begin
                    n_sweep_addr = r_sweep_addr + WORD_AW'(1);
                end
            end

            fcsm_pkg::S_PROG: begin
                // Bits that could not go from 0 to 1 flag a program error
                if (prog_word != r_prog_data) begin
                    n_err = 1'b1;
                end
                n_state = fcsm_pkg::S_IDLE;
            end

            fcsm_pkg::S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    case (action)
                        fcsm_pkg::ACT_READ: begin
                            case (r_mode)
                                fcsm_pkg::MODE_ID: begin
                                    if (off == OFF_W'(0)) begin
                                        n_result = r_manuf_id;
                                    end else if (off == OFF_W'(2)) begin
                                        n_result = r_device_id;
                                    end
                                end
                                fcsm_pkg::MODE_STATUS: begin
                                    n_result = fcsm_pkg::STATUS_DONE
                                             | (r_err ? fcsm_pkg::STATUS_PGM_ERR : '0);
                                end
                                default: begin
                                    n_use_ram = 1'b1;
                                end
                            endcase
                        end

                        fcsm_pkg::ACT_WRITE: begin
                            n_pend = fcsm_pkg::PEND_NONE;
                            if (r_pend == fcsm_pkg::PEND_PROGRAM) begin
                                // RAM read issued this cycle, write-back next
                                n_state     = fcsm_pkg::S_PROG;
                                n_prog_idx  = word_idx;
                                n_prog_data = i_write_data;
                                n_mode      = fcsm_pkg::MODE_STATUS;
                            end else if (r_pend == fcsm_pkg::PEND_ERASE
                                         && cmd == fcsm_pkg::CMD_CONFIRM) begin
                                n_state      = fcsm_pkg::S_ERASE;
                                n_sweep_addr = word_idx & ~fcsm_pkg::ERASE_MASK;
                                n_sweep_mask = fcsm_pkg::ERASE_MASK;
                                n_mode       = fcsm_pkg::MODE_STATUS;
                            end else if (r_pend == fcsm_pkg::PEND_LOCK
                                         && (cmd == fcsm_pkg::CMD_CONFIRM
                                             || cmd == fcsm_pkg::CMD_LOCK_ALT)) begin
                                n_mode = fcsm_pkg::MODE_STATUS;
                            end else begin
                                case (cmd)
                                    fcsm_pkg::CMD_READ_ARRAY:  n_mode = fcsm_pkg::MODE_ARRAY;
                                    fcsm_pkg::CMD_READ_ID:     n_mode = fcsm_pkg::MODE_ID;
                                    fcsm_pkg::CMD_READ_STATUS: n_mode = fcsm_pkg::MODE_STATUS;
                                    fcsm_pkg::CMD_CLEAR_STATUS: begin
                                        n_err  = 1'b0;
                                        n_mode = fcsm_pkg::MODE_STATUS;
                                    end
                                    fcsm_pkg::CMD_PROGRAM,
                                    fcsm_pkg::CMD_PROGRAM_ALT: n_pend = fcsm_pkg::PEND_PROGRAM;
                                    fcsm_pkg::CMD_ERASE_SETUP: n_pend = fcsm_pkg::PEND_ERASE;
                                    fcsm_pkg::CMD_LOCK_SETUP:  n_pend = fcsm_pkg::PEND_LOCK;
                                    fcsm_pkg::CMD_SUSPEND,
                                    fcsm_pkg::CMD_CONFIRM:     n_mode = fcsm_pkg::MODE_STATUS;
                                    default: ;
                                endcase
                            end
                        end

                        fcsm_pkg::ACT_RESET: begin
                            n_mode = fcsm_pkg::MODE_ARRAY;
                            n_pend = fcsm_pkg::PEND_NONE;
                            n_err  = 1'b0;
                        end

                        default: ;
                    endcase
                end
            end

            default: begin
                n_state = fcsm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fcsm_pkg::S_CLEAR;
            r_mode       <= fcsm_pkg::MODE_ARRAY;
            r_pend       <= fcsm_pkg::PEND_NONE;
            r_err        <= 1'b0;
            r_strobe     <= 1'b0;
            r_use_ram    <= 1'b0;
            r_sweep_addr <= '0;
            r_sweep_mask <= fcsm_pkg::FULL_MASK;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_pend       <= n_pend;
            r_err        <= n_err;
            r_strobe     <= n_strobe;
            r_use_ram    <= n_use_ram;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_mask <= n_sweep_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result    <= n_result;
        r_prog_idx  <= n_prog_idx;
        r_prog_data <= n_prog_data;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manuf_id  <= fcsm_pkg::MANUF_ID_RESET;
            r_device_id <= fcsm_pkg::DEVICE_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fcsm_pkg::CFG_MANUF_ID:  r_manuf_id  <= i_cfg_wdata;
                fcsm_pkg::CFG_DEVICE_ID: r_device_id <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Array reads come straight from the RAM output register
    assign o_strobe    = r_strobe;
    assign o_read_data = r_use_ram ? ram_rdata : r_result;

endmodule

// File: bench/flash_command_state_machine_tb.sv
// Self-checking testbench for the flash command state machine: directed table, then random traffic.
`timescale 1ns / 1ps

module flash_command_state_machine_tb;

    localparam int ADDR_W      = fcsm_pkg::ADDR_W;
    localparam int DATA_W      = fcsm_pkg::DATA_W;
    localparam int CMD_W       = fcsm_pkg::CMD_W;
    localparam int WORD_AW     = fcsm_pkg::WORD_AW;
    localparam int WORD_COUNT  = fcsm_pkg::WORD_COUNT;
    localparam int ARRAY_BYTES = fcsm_pkg::ARRAY_BYTES;
    localparam int BLOCK_BYTES = fcsm_pkg::BLOCK_BYTES;

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_action;
    logic [ADDR_W-1:0]   i_address;
    logic [DATA_W-1:0]   i_write_data;
    logic                o_strobe;
    logic [DATA_W-1:0]   o_read_data;
    logic                i_cfg_we;
    logic                i_cfg_index;
    logic [DATA_W-1:0]   i_cfg_wdata;

    flash_command_state_machine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_strobe     (o_strobe),
        .o_read_data  (o_read_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop; covers the clearing sweep after reset plus every block erase
    // the stimulus allows, several times over.
    initial begin
        #6_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the device: array, mode, pending command, error flag
    // and the two ID registers.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] flash_mem [0:WORD_COUNT-1];
    fcsm_pkg::t_mode   cur_mode;
    fcsm_pkg::t_pend   cur_pend;
    logic              pgm_err;
    logic [DATA_W-1:0] man_id;
    logic [DATA_W-1:0] dev_id;

    // Words still owed by the DUT, oldest first
    logic [DATA_W-1:0] expected_words [$];
    logic [DATA_W-1:0] next_word;
    int                mismatches;

    // Stimulus knobs
    int idle_pct;          // chance (percent) that the sender skips a cycle
    int items_sent;
    int erases_left;       // each erase confirm costs a full block sweep

    function automatic logic [WORD_AW-1:0] word_index(logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] off;
        off = addr & ADDR_W'(ARRAY_BYTES - 1);
        return off[WORD_AW:1];
    endfunction

    // Applies one transaction to the shadow state and returns the word the
    // bus should see for it.
    function automatic logic [DATA_W-1:0] flash_access(fcsm_pkg::t_action act,
                                                       logic [ADDR_W-1:0] addr,
                                                       logic [DATA_W-1:0] data);
        logic [ADDR_W-1:0]  off;
        logic [WORD_AW-1:0] idx;
        logic [CMD_W-1:0]   cmd;
        logic [DATA_W-1:0]  merged;
        fcsm_pkg::t_pend    was_pending;
        int                 first;
        int                 last;

        off = addr & ADDR_W'(ARRAY_BYTES - 1);
        off[0] = 1'b0;
        idx = off[WORD_AW:1];
        cmd = data[CMD_W-1:0];

        case (act)
            fcsm_pkg::ACT_READ: begin
                case (cur_mode)
                    fcsm_pkg::MODE_ID: begin
                        if (off == 0) return man_id;
                        if (off == 2) return dev_id;
                        return '0;
                    end
                    fcsm_pkg::MODE_STATUS: begin
                        return fcsm_pkg::STATUS_DONE
                             | (pgm_err ? fcsm_pkg::STATUS_PGM_ERR : '0);
                    end
                    default: return flash_mem[idx];
                endcase
            end
            fcsm_pkg::ACT_RESET: begin
                cur_mode = fcsm_pkg::MODE_ARRAY;
                cur_pend = fcsm_pkg::PEND_NONE;
                pgm_err  = 1'b0;
                return '0;
            end
            fcsm_pkg::ACT_WRITE: begin
                was_pending = cur_pend;
                cur_pend    = fcsm_pkg::PEND_NONE;
                // second half of program: data is never a command
                if (was_pending == fcsm_pkg::PEND_PROGRAM) begin
                    merged = flash_mem[idx] & data;
                    flash_mem[idx] = merged;
                    if (merged != data) pgm_err = 1'b1;
                    cur_mode = fcsm_pkg::MODE_STATUS;
                    return '0;
                end
                if (was_pending == fcsm_pkg::PEND_ERASE && cmd == fcsm_pkg::CMD_CONFIRM) begin
                    first = (int'(off) / BLOCK_BYTES) * (BLOCK_BYTES / 2);
                    last  = first + BLOCK_BYTES / 2;
                    if (last > WORD_COUNT) last = WORD_COUNT;
                    for (int i = first; i < last; i++) flash_mem[i] = fcsm_pkg::ERASED_WORD;
                    cur_mode = fcsm_pkg::MODE_STATUS;
                    return '0;
                end
                if (was_pending == fcsm_pkg::PEND_LOCK
                    && (cmd == fcsm_pkg::CMD_CONFIRM || cmd == fcsm_pkg::CMD_LOCK_ALT)) begin
                    cur_mode = fcsm_pkg::MODE_STATUS;
                    return '0;
                end
                // unconfirmed setup falls through and is decoded normally
                case (cmd)
                    fcsm_pkg::CMD_READ_ARRAY:  cur_mode = fcsm_pkg::MODE_ARRAY;
                    fcsm_pkg::CMD_READ_ID:     cur_mode = fcsm_pkg::MODE_ID;
                    fcsm_pkg::CMD_READ_STATUS: cur_mode = fcsm_pkg::MODE_STATUS;
                    fcsm_pkg::CMD_CLEAR_STATUS: begin
                        pgm_err  = 1'b0;
                        cur_mode = fcsm_pkg::MODE_STATUS;
                    end
                    fcsm_pkg::CMD_PROGRAM, fcsm_pkg::CMD_PROGRAM_ALT: begin
                        cur_pend = fcsm_pkg::PEND_PROGRAM;
                    end
                    fcsm_pkg::CMD_ERASE_SETUP: cur_pend = fcsm_pkg::PEND_ERASE;
                    fcsm_pkg::CMD_LOCK_SETUP:  cur_pend = fcsm_pkg::PEND_LOCK;
                    fcsm_pkg::CMD_SUSPEND, fcsm_pkg::CMD_CONFIRM: begin
                        cur_mode = fcsm_pkg::MODE_STATUS;
                    end
                    default: ;
                endcase
                return '0;
            end
            default: return '0;   // unused action: no effect
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Bus driver. Drives on the falling edge, samples busy on the rising
    // edge; a transaction is taken on the first edge with busy low. The
    // expectation is queued at that edge, in the cycle before its strobe.
    // ------------------------------------------------------------------
    task automatic send(input fcsm_pkg::t_action act, input logic [ADDR_W-1:0] addr,
                        input logic [DATA_W-1:0] data,
                        input bit fixed = 1'b0, input logic [DATA_W-1:0] want = '0);
        logic [DATA_W-1:0] word;
        // random sender gaps
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        // erase confirms are expensive: once the budget is spent, spoil the
        // confirm so the setup is simply dropped
        if (act == fcsm_pkg::ACT_WRITE && cur_pend == fcsm_pkg::PEND_ERASE
            && data[CMD_W-1:0] == fcsm_pkg::CMD_CONFIRM) begin
            if (erases_left == 0) data[CMD_W-1:0] = fcsm_pkg::CMD_CONFIRM ^ 8'h01;
            else erases_left--;
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_action     <= act;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (busy !== 1'b0);
        word = flash_access(act, addr, data);
        expected_words.push_back(fixed ? want : word);
        items_sent++;
    endtask

    // Stop sending and wait until every owed word is back and any erase
    // sweep has finished; registers may be written after this.
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_words.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_ids(input logic [DATA_W-1:0] manuf, input logic [DATA_W-1:0] device);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fcsm_pkg::CFG_MANUF_ID;
        i_cfg_wdata <= manuf;
        @(posedge i_clk);
        man_id = manuf;
        @(negedge i_clk);
        i_cfg_index <= fcsm_pkg::CFG_DEVICE_ID;
        i_cfg_wdata <= device;
        @(posedge i_clk);
        dev_id = device;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a handful of hot words so programs and reads collide; the
    // low bit is flipped at random since the device ignores it.
    function automatic logic [ADDR_W-1:0] hot_address();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(7))
            0: a = '0;
            1: a = ADDR_W'(2);
            2: a = ADDR_W'(ARRAY_BYTES - 2);
            3: a = ADDR_W'(BLOCK_BYTES);
            4: a = ADDR_W'(BLOCK_BYTES - 2);
            default: a = ADDR_W'($urandom);
        endcase
        a[0] = 1'($urandom_range(1));
        return a;
    endfunction

    function automatic logic [CMD_W-1:0] plain_command();
        case ($urandom_range(6))
            0: return fcsm_pkg::CMD_READ_ARRAY;
            1: return fcsm_pkg::CMD_READ_ID;
            2: return fcsm_pkg::CMD_READ_STATUS;
            3: return fcsm_pkg::CMD_CLEAR_STATUS;
            4: return fcsm_pkg::CMD_SUSPEND;
            5: return fcsm_pkg::CMD_CONFIRM;
            default: return CMD_W'($urandom);   // usually an unknown code
        endcase
    endfunction

    // One short, mostly well-formed command sequence with random content.
    task automatic random_burst();
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [CMD_W-1:0]  tail;
        int                kind;
        kind = $urandom_range(99);
        addr = hot_address();
        if (kind < 25) begin
            repeat ($urandom_range(1, 4)) begin
                send(fcsm_pkg::ACT_READ, hot_address(), DATA_W'($urandom));
            end
        end else if (kind < 40) begin
            send(fcsm_pkg::ACT_WRITE, addr, {CMD_W'($urandom), plain_command()});
        end else if (kind < 63) begin
            // program: half of them clear only bits that are still set
            send(fcsm_pkg::ACT_WRITE, hot_address(),
                 {CMD_W'($urandom),
                  ($urandom_range(1) ? fcsm_pkg::CMD_PROGRAM : fcsm_pkg::CMD_PROGRAM_ALT)});
            data = DATA_W'($urandom);
            if ($urandom_range(1)) data = data & flash_mem[word_index(addr)];
            send(fcsm_pkg::ACT_WRITE, addr, data);
            send(fcsm_pkg::ACT_READ, hot_address(), DATA_W'($urandom));
            if ($urandom_range(1)) begin
                send(fcsm_pkg::ACT_WRITE, addr, {CMD_W'($urandom), fcsm_pkg::CMD_READ_ARRAY});
            end
            send(fcsm_pkg::ACT_READ, addr, DATA_W'($urandom));
        end else if (kind < 72) begin
            send(fcsm_pkg::ACT_WRITE, hot_address(),
                 {CMD_W'($urandom), fcsm_pkg::CMD_ERASE_SETUP});
            tail = $urandom_range(1) ? fcsm_pkg::CMD_CONFIRM : plain_command();
            send(fcsm_pkg::ACT_WRITE, addr, {CMD_W'($urandom), tail});
        end else if (kind < 81) begin
            send(fcsm_pkg::ACT_WRITE, hot_address(),
                 {CMD_W'($urandom), fcsm_pkg::CMD_LOCK_SETUP});
            case ($urandom_range(2))
                0: tail = fcsm_pkg::CMD_CONFIRM;
                1: tail = fcsm_pkg::CMD_LOCK_ALT;
                default: tail = plain_command();
            endcase
            send(fcsm_pkg::ACT_WRITE, addr, {CMD_W'($urandom), tail});
        end else if (kind < 86) begin
            send(fcsm_pkg::ACT_RESET, ADDR_W'($urandom), DATA_W'($urandom));
        end else if (kind < 89) begin
            send(fcsm_pkg::ACT_NONE, ADDR_W'($urandom), DATA_W'($urandom));
        end else begin
            // noise: anything at all
            send(fcsm_pkg::t_action'($urandom_range(3)), ADDR_W'($urandom),
                 DATA_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table. Writes always read back zero; reads carry the value
    // where it is obvious, else the shadow model supplies it.
    // ------------------------------------------------------------------
    typedef struct packed {
        fcsm_pkg::t_action act;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              fixed;
        logic [DATA_W-1:0] want;
    } t_row;

    localparam int SCRIPT_LEN = 29;

    // Runs with manufacturer ID 0x0000 and device ID 0xffff
    t_row script [0:SCRIPT_LEN-1] = '{
        '{fcsm_pkg::ACT_READ,  17'h00000, 16'h0000, 1'b1, fcsm_pkg::ERASED_WORD},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_READ_ID}, 1'b1, 16'h0000},
        // odd -> offset 0
        '{fcsm_pkg::ACT_READ,  17'h00001, 16'hffff, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_READ,  17'h00002, 16'h0000, 1'b1, 16'hffff},
        // other ID offset
        '{fcsm_pkg::ACT_READ,  17'h1fffc, 16'h0000, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_PROGRAM}, 1'b1, 16'h0000},
        // programs, not decoded
        '{fcsm_pkg::ACT_WRITE, 17'h1ffff, {8'h12, fcsm_pkg::CMD_READ_ARRAY}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_READ,  17'h00000, 16'h0000, 1'b1, fcsm_pkg::STATUS_DONE},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_PROGRAM_ALT}, 1'b1, 16'h0000},
        // can't set bits
        '{fcsm_pkg::ACT_WRITE, 17'h1fffe, 16'hffff, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_READ,  17'h00000, 16'h0000, 1'b1,
          fcsm_pkg::STATUS_DONE | fcsm_pkg::STATUS_PGM_ERR},
        '{fcsm_pkg::ACT_NONE,  17'h1ffff, 16'hffff, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_READ,  17'h00000, 16'h0000, 1'b1,
          fcsm_pkg::STATUS_DONE | fcsm_pkg::STATUS_PGM_ERR},
        '{fcsm_pkg::ACT_RESET, 17'h1ffff, 16'hffff, 1'b1, 16'h0000},
        // array kept
        '{fcsm_pkg::ACT_READ,  17'h1fffe, 16'h0000, 1'b0, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'hff, fcsm_pkg::CMD_READ_STATUS}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_READ,  17'h00000, 16'h0000, 1'b1, fcsm_pkg::STATUS_DONE},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_ERASE_SETUP}, 1'b1, 16'h0000},
        // no confirm
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_READ_ID}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_READ,  17'h00000, 16'h0000, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_LOCK_SETUP}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_LOCK_ALT}, 1'b1, 16'h0000},
        // unknown code
        '{fcsm_pkg::ACT_WRITE, 17'h00000, 16'h00ab, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_SUSPEND}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_CLEAR_STATUS}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_ERASE_SETUP}, 1'b1, 16'h0000},
        // top block
        '{fcsm_pkg::ACT_WRITE, 17'h10000, {8'hab, fcsm_pkg::CMD_CONFIRM}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_WRITE, 17'h00000, {8'h00, fcsm_pkg::CMD_READ_ARRAY}, 1'b1, 16'h0000},
        '{fcsm_pkg::ACT_READ,  17'h1fffe, 16'h0000, 1'b1, fcsm_pkg::ERASED_WORD}
    };

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest owed word.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: read_data expected none, got %h", $time, o_read_data);
            end else begin
                next_word = expected_words.pop_front();
                if (o_read_data !== next_word) begin
                    mismatches++;
                    $display("%0t: read_data expected %h, got %h",
                             $time, next_word, o_read_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_action     = fcsm_pkg::ACT_READ;
        i_address    = '0;
        i_write_data = '0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = fcsm_pkg::CFG_MANUF_ID;
        i_cfg_wdata  = '0;
        mismatches   = 0;
        items_sent   = 0;
        idle_pct     = 0;
        erases_left  = 8;
        for (int i = 0; i < WORD_COUNT; i++) flash_mem[i] = fcsm_pkg::ERASED_WORD;
        cur_mode = fcsm_pkg::MODE_ARRAY;
        cur_pend = fcsm_pkg::PEND_NONE;
        pgm_err  = 1'b0;
        man_id   = fcsm_pkg::MANUF_ID_RESET;
        dev_id   = fcsm_pkg::DEVICE_ID_RESET;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // IDs may be loaded while the clearing sweep runs
        load_ids(16'h0000, 16'hffff);
        for (int i = 0; i < SCRIPT_LEN; i++)
            send(script[i].act, script[i].addr, script[i].data, script[i].fixed, script[i].want);

        // Three random phases: light gaps, heavy gaps, none. Each starts
        // from a drained bus with fresh ID values.
        for (int phase = 0; phase < 3; phase++) begin
            drain();
            case (phase)
                0: begin
                    load_ids(DATA_W'($urandom), DATA_W'($urandom));
                    idle_pct = 20;
                end
                1: begin
                    load_ids(16'hffff, 16'h0000);
                    idle_pct = 48;
                end
                default: begin
                    load_ids(DATA_W'($urandom), DATA_W'($urandom));
                    idle_pct = 0;
                end
            endcase
            items_sent = 0;
            while (items_sent < 500) random_burst();
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
